### sv/knn_pkg.sv
// knn_pkg: shared types and constants for the knn fraud score unit
// no dependencies
`timescale 1ns / 1ps

package knn_pkg;

    localparam int LANE_BITS  = 16;
    localparam int COUNT_BITS = 13;
    localparam int INDEX_BITS = 12;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SCORE,
        ST_OUT
    } knn_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_query;
        logic write_ref;
        logic clear_best;
        logic scan_en;
        logic score_start;
        logic out_load;
    } knn_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic pipe_empty;
        logic score_done;
    } knn_status_t;

endpackage

### sv/knn_ifc.sv
// knn_ifc: valid/ready channel interfaces for requests, results and config
// no dependencies
`timescale 1ns / 1ps

interface knn_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [11:0] entry_index;
    logic [63:0] feat_a;
    logic [63:0] feat_b;
    logic [63:0] feat_c;
    logic [31:0] feat_d;
    logic        is_fraud;
    modport source (output valid, req_type, entry_index, feat_a, feat_b, feat_c, feat_d,
                    is_fraud, input ready);
    modport sink (input valid, req_type, entry_index, feat_a, feat_b, feat_c, feat_d,
                  is_fraud, output ready);
endinterface

interface knn_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  fraud_hits;
    logic [2:0]  neighbor_count;
    logic [15:0] score;
    modport source (output valid, fraud_hits, neighbor_count, score, input ready);
    modport sink (input valid, fraud_hits, neighbor_count, score, output ready);
endinterface

interface knn_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### sv/knn_ram.sv
// knn_ram: generic single port write, single port read ram, registered read
// no dependencies
`timescale 1ns / 1ps

module knn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/knn_ctrl.sv
// knn_ctrl: controller state machine, sequences loads, scans and scoring
// depends on knn_pkg
`timescale 1ns / 1ps

module knn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_type,
    output logic                req_ready,
    input  logic                res_ready,
    output logic                res_valid,
    input  logic                scan_last,
    input  logic                scan_none,
    input  knn_pkg::knn_status_t status,
    output knn_pkg::knn_cmd_t    cmd
);
    import knn_pkg::*;

    knn_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_type == REQ_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        cmd.clear_best = 1'b1;
                        state_next     = scan_none ? ST_DRAIN : ST_SCAN;
                    end
                    else
                    begin
                        cmd.write_ref = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    cmd.score_start = 1'b1;
                    state_next      = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                if (status.score_done)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a result is offered only from the output state
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> state_reg == ST_OUT)
        else $error("result offered outside output state");
    // scoring starts only with an empty pipeline
    a_score_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.score_start |-> status.pipe_empty)
        else $error("score started with work in flight");
    // no request taken while a query is in progress
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req_ready)
        else $error("request accepted while busy");

endmodule

### sv/knn_dp.sv
// knn_dp: datapath with reference memory, distance pipeline, top-k list and divider
// depends on knn_pkg and knn_ram
`timescale 1ns / 1ps

module knn_dp #(
    parameter int MAX_ENTRIES  = 4096,
    parameter int NUM_FEATURES = 14,
    parameter int K_NEIGHBORS  = 5,
    parameter int FEATURE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  knn_pkg::knn_cmd_t    cmd,
    output knn_pkg::knn_status_t status,
    input  logic [11:0]         entry_index,
    input  logic [63:0]         feat_a,
    input  logic [63:0]         feat_b,
    input  logic [63:0]         feat_c,
    input  logic [31:0]         feat_d,
    input  logic                is_fraud,
    input  logic [12:0]         entry_count,
    output logic                scan_last,
    output logic                scan_none,
    output logic [2:0]          fraud_hits,
    output logic [2:0]          neighbor_count,
    output logic [15:0]         score
);
    import knn_pkg::*;

    localparam int ADDR_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RAM_DEPTH = 1 << ADDR_BITS;
    localparam int SCAN_BITS = ADDR_BITS + 1;
    localparam int VEC_BITS  = NUM_FEATURES * FEATURE_BITS;
    localparam int DIFF_BITS = FEATURE_BITS + 1;
    localparam int SQ_BITS   = 2 * DIFF_BITS;
    localparam int DIST_BITS = SQ_BITS + 4;
    localparam int KC_BITS   = $clog2(K_NEIGHBORS + 1);
    localparam int SCORE_W   = 16;

    logic [4*64+32-1:0] in_lanes;
    logic [VEC_BITS-1:0] wvec;
    logic [VEC_BITS-1:0] rvec;
    logic               rfraud;
    logic [VEC_BITS-1:0] query_reg;
    logic [SCAN_BITS-1:0] addr_reg, addr_next;
    logic [SCAN_BITS-1:0] limit;
    logic [ADDR_BITS-1:0] raddr;
    logic               wr_ok;

    // pack incoming lanes into the memory word
    assign in_lanes = {feat_d, feat_c, feat_b, feat_a};
    always_comb
    begin
        for (int d = 0; d < NUM_FEATURES; d++)
        begin
            wvec[d*FEATURE_BITS +: FEATURE_BITS] = in_lanes[d*LANE_BITS +: FEATURE_BITS];
        end
    end

    assign wr_ok = cmd.write_ref && ({1'b0, entry_index} < 13'(MAX_ENTRIES));

    knn_ram #(.WIDTH(VEC_BITS + 1), .DEPTH(RAM_DEPTH)) u_ref_ram (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (entry_index[ADDR_BITS-1:0]),
        .wdata ({is_fraud, wvec}),
        .raddr (raddr),
        .rdata ({rfraud, rvec})
    );

    // scan limit, clipped to capacity
    always_comb
    begin
        if ({1'b0, entry_count} > 14'(MAX_ENTRIES))
        begin
            limit = SCAN_BITS'(MAX_ENTRIES);
        end
        else
        begin
            limit = SCAN_BITS'(entry_count);
        end
    end
    assign scan_none = (limit == '0);
    assign scan_last = cmd.scan_en && (addr_reg == limit - 1'b1);
    assign raddr     = addr_reg[ADDR_BITS-1:0];
    assign addr_next = cmd.load_query ? '0 : (cmd.scan_en ? addr_reg + 1'b1 : addr_reg);

    // scan address and query hold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else
        begin
            addr_reg <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            query_reg <= wvec;
        end
    end

    // pipeline valid: ram read, square, sum
    logic v1_reg, v2_reg, v3_reg;
    logic f2_reg, f3_reg;
    logic [SQ_BITS-1:0] sq_reg [NUM_FEATURES];
    logic [DIST_BITS-1:0] dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // per feature difference squared, at full product width
    always_ff @(posedge clk)
    begin
        for (int d = 0; d < NUM_FEATURES; d++)
        begin
            logic signed [DIFF_BITS-1:0] df;
            logic signed [SQ_BITS-1:0]   dx;
            df = DIFF_BITS'($signed(query_reg[d*FEATURE_BITS +: FEATURE_BITS]))
               - DIFF_BITS'($signed(rvec[d*FEATURE_BITS +: FEATURE_BITS]));
            dx = SQ_BITS'(df);
            sq_reg[d] <= $unsigned(dx * dx);
        end
        f2_reg <= rfraud;
    end

    // sum of squares
    always_ff @(posedge clk)
    begin
        logic [DIST_BITS-1:0] acc;
        acc = '0;
        for (int d = 0; d < NUM_FEATURES; d++)
        begin
            acc = acc + DIST_BITS'(sq_reg[d]);
        end
        dist_reg <= acc;
        f3_reg   <= f2_reg;
    end

    assign status.pipe_empty = !v1_reg && !v2_reg && !v3_reg && !cmd.scan_en;

    // sorted top-k insertion list
    logic [DIST_BITS-1:0] bd_reg [K_NEIGHBORS];
    logic                 bf_reg [K_NEIGHBORS];
    logic [KC_BITS-1:0]   bc_reg;
    logic                 take;
    logic [K_NEIGHBORS-1:0] gt;

    always_comb
    begin
        for (int k = 0; k < K_NEIGHBORS; k++)
        begin
            gt[k] = (KC_BITS'(k) < bc_reg) && (bd_reg[k] > dist_reg);
        end
        take = (bc_reg < KC_BITS'(K_NEIGHBORS)) || gt[K_NEIGHBORS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg <= '0;
            for (int k = 0; k < K_NEIGHBORS; k++)
            begin
                bd_reg[k] <= '0;
                bf_reg[k] <= 1'b0;
            end
        end
        else if (cmd.clear_best)
        begin
            bc_reg <= '0;
            for (int k = 0; k < K_NEIGHBORS; k++)
            begin
                bd_reg[k] <= '0;
                bf_reg[k] <= 1'b0;
            end
        end
        else if (v3_reg && take)
        begin
            if (bc_reg < KC_BITS'(K_NEIGHBORS))
            begin
                bc_reg <= bc_reg + 1'b1;
            end
            for (int k = 0; k < K_NEIGHBORS; k++)
            begin
                if (gt[k])
                begin
                    if (k == 0 || !gt[k-1])
                    begin
                        bd_reg[k] <= dist_reg;
                        bf_reg[k] <= f3_reg;
                    end
                    else
                    begin
                        bd_reg[k] <= bd_reg[k-1];
                        bf_reg[k] <= bf_reg[k-1];
                    end
                end
                else if (KC_BITS'(k) == bc_reg)
                begin
                    if (k == 0 || !gt[k-1])
                    begin
                        bd_reg[k] <= dist_reg;
                        bf_reg[k] <= f3_reg;
                    end
                    else
                    begin
                        bd_reg[k] <= bd_reg[k-1];
                        bf_reg[k] <= bf_reg[k-1];
                    end
                end
            end
        end
    end

    // count fraud labels among kept neighbors
    logic [KC_BITS-1:0] frauds;
    always_comb
    begin
        frauds = '0;
        for (int k = 0; k < K_NEIGHBORS; k++)
        begin
            if (KC_BITS'(k) < bc_reg && bf_reg[k])
            begin
                frauds = frauds + 1'b1;
            end
        end
    end

    // restoring divider: frauds * 32768 / count, one quotient bit per cycle
    localparam int NUM_W = KC_BITS + 15;
    localparam int REM_W = KC_BITS + 1;
    logic [NUM_W-1:0] num_reg;
    logic [REM_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [4:0]       step_reg;
    logic             busy_reg;
    logic [REM_W-1:0] rem_shift;
    logic             ge;

    assign rem_shift = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign ge        = rem_shift >= REM_W'(bc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (cmd.score_start)
        begin
            busy_reg <= 1'b1;
            step_reg <= 5'(NUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.score_start)
        begin
            num_reg <= {frauds, 15'd0};
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? rem_shift - REM_W'(bc_reg) : rem_shift;
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign status.score_done = busy_reg && (step_reg == 5'd1) ? 1'b0 : !busy_reg;

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            fraud_hits     <= 3'(frauds);
            neighbor_count <= 3'(bc_reg);
            score          <= (bc_reg == '0) ? '0 : SCORE_W'(quo_reg);
        end
    end

    // kept count never exceeds k
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        bc_reg <= KC_BITS'(K_NEIGHBORS))
        else $error("neighbor count above k");
    // kept list stays sorted, checked on its first two entries
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (bc_reg >= KC_BITS'(2)) |-> bd_reg[0] <= bd_reg[1])
        else $error("neighbor list out of order");
    // list is cleared after a query starts
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_best |=> bc_reg == '0)
        else $error("neighbor list not cleared");

endmodule

### sv/knn_five_fraud_score_unit.sv
// knn five nearest neighbor fraud scorer, top level
// a load word is written to the reference memory; a query scans min(entry_count, MAX_ENTRIES)
// stored entries, one stored entry per cycle through the reference memory read port,
// then drains the pipeline, runs the divider and waits for the result to be taken
// throughput: one load per cycle while no query is in progress; one query at a time
// reset: rst_n clears the controller, entry_count, pipeline valids and the list
`timescale 1ns / 1ps

module knn_five_fraud_score_unit #(
    parameter int MAX_ENTRIES  = 4096,
    parameter int NUM_FEATURES = 14,
    parameter int K_NEIGHBORS  = 5,
    parameter int FEATURE_BITS = 16
) (
    input logic       clk,
    input logic       rst_n,
    knn_req_if.sink   req,
    knn_res_if.source res,
    knn_cfg_if.sink   cfg
);
    import knn_pkg::*;

    knn_cmd_t    cmd;
    knn_status_t status;
    logic        scan_last;
    logic        scan_none;
    logic [COUNT_BITS-1:0] entry_count_reg;

    // configuration register
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            entry_count_reg <= cfg.data;
        end
    end

    knn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .res_ready (res.ready),
        .res_valid (res.valid),
        .scan_last (scan_last),
        .scan_none (scan_none),
        .status    (status),
        .cmd       (cmd)
    );

    knn_dp #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .NUM_FEATURES (NUM_FEATURES),
        .K_NEIGHBORS  (K_NEIGHBORS),
        .FEATURE_BITS (FEATURE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .entry_index    (req.entry_index),
        .feat_a         (req.feat_a),
        .feat_b         (req.feat_b),
        .feat_c         (req.feat_c),
        .feat_d         (req.feat_d),
        .is_fraud       (req.is_fraud),
        .entry_count    (entry_count_reg),
        .scan_last      (scan_last),
        .scan_none      (scan_none),
        .fraud_hits     (res.fraud_hits),
        .neighbor_count (res.neighbor_count),
        .score          (res.score)
    );

endmodule

### dv/tb.sv
// tb: self-checking testbench for knn_five_fraud_score_unit
// depends on knn_pkg, knn_ifc and the unit's rtl
`timescale 1ns / 1ps

module tb;
    import knn_pkg::*;

    localparam int SLOTS          = 4096;
    localparam int FEATS          = 14;
    localparam int NEAREST        = 5;
    localparam int NEAR_SLOTS     = 32;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic        req_type;
        logic [11:0] entry_index;
        logic [15:0] lane [FEATS];
        logic        is_fraud;
    } knn_word_t;

    typedef struct packed {
        logic [2:0]  fraud_hits;
        logic [2:0]  neighbor_count;
        logic [15:0] score;
    } knn_score_t;

    logic clk;
    logic rst_n;

    knn_req_if req_ch ();
    knn_res_if res_ch ();
    knn_cfg_if cfg_ch ();

    knn_five_fraud_score_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // reference store and search count as the scorer sees them
    logic [15:0] stored_lane [SLOTS][FEATS];
    bit          stored_fraud [SLOTS];
    int unsigned search_count;

    // generator side bookkeeping
    logic [15:0] plan_lane [NEAR_SLOTS][FEATS];

    knn_word_t  pending_words [$];
    knn_score_t expected_scores [$];
    int         failures;
    bit         quiet;
    bit         req_took;
    int         send_gap;
    int         hold_left;
    int         long_hold_requests;
    int         long_hold_done;
    int         idle_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // fraud score of a query against the first search_count slots
    function automatic knn_score_t score_query(knn_word_t w);
        logic [63:0] near_dist [NEAREST];
        bit          near_fraud [NEAREST];
        int          kept;
        int          pos;
        int          n;
        int          frauds;
        logic [63:0] sq_sum;
        longint      diff;
        knn_score_t  s;
        kept = 0;
        n = (search_count > SLOTS) ? SLOTS : int'(search_count);
        for (int i = 0; i < n; i++)
        begin
            sq_sum = 0;
            for (int d = 0; d < FEATS; d++)
            begin
                diff = longint'($signed(w.lane[d])) - longint'($signed(stored_lane[i][d]));
                sq_sum += diff * diff;
            end
            if (kept < NEAREST)
            begin
                pos = kept;
                kept++;
            end
            else if (sq_sum < near_dist[NEAREST-1])
                pos = NEAREST - 1;
            else
                continue;
            // ties keep the earlier entry ahead
            while (pos > 0 && near_dist[pos-1] > sq_sum)
            begin
                near_dist[pos]  = near_dist[pos-1];
                near_fraud[pos] = near_fraud[pos-1];
                pos--;
            end
            near_dist[pos]  = sq_sum;
            near_fraud[pos] = stored_fraud[i];
        end
        frauds = 0;
        for (int k = 0; k < kept; k++)
            if (near_fraud[k])
                frauds++;
        s.fraud_hits     = 3'(frauds);
        s.neighbor_count = 3'(kept);
        s.score          = (kept != 0) ? 16'((frauds * 32768) / kept) : 16'd0;
        return s;
    endfunction

    function automatic logic [15:0] random_lane();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic knn_word_t flat_word(logic kind, int slot, bit fraud, logic [15:0] v);
        knn_word_t w;
        w.req_type    = kind;
        w.entry_index = 12'(slot);
        w.is_fraud    = fraud;
        for (int d = 0; d < FEATS; d++)
            w.lane[d] = v;
        return w;
    endfunction

    task automatic push_load(knn_word_t w);
        w.req_type = REQ_LOAD;
        if (w.entry_index < NEAR_SLOTS)
            plan_lane[w.entry_index] = w.lane;
        pending_words.push_back(w);
    endtask

    // wait until the unit is idle with nothing outstanding
    task automatic settle();
        while (pending_words.size() != 0 || req_ch.valid || expected_scores.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(int unsigned value);
        settle();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= 13'(value);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        search_count = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // request driver
    always @(negedge clk)
    begin
        knn_word_t w;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_took)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                w = pending_words.pop_front();
                req_ch.req_type    <= w.req_type;
                req_ch.entry_index <= w.entry_index;
                req_ch.feat_a      <= {w.lane[3], w.lane[2], w.lane[1], w.lane[0]};
                req_ch.feat_b      <= {w.lane[7], w.lane[6], w.lane[5], w.lane[4]};
                req_ch.feat_c      <= {w.lane[11], w.lane[10], w.lane[9], w.lane[8]};
                req_ch.feat_d      <= {w.lane[13], w.lane[12]};
                req_ch.is_fraud    <= w.is_fraud;
                req_ch.valid       <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 3);
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if (long_hold_done != long_hold_requests)
        begin
            long_hold_done++;
            hold_left = LONG_HOLD - 1;
            res_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            hold_left = $urandom_range(0, 2);
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // request monitor: update the store or predict a score
    always @(posedge clk)
    begin
        knn_word_t w;
        req_took <= req_ch.valid && req_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            w.req_type    = req_ch.req_type;
            w.entry_index = req_ch.entry_index;
            w.is_fraud    = req_ch.is_fraud;
            for (int d = 0; d < 4; d++)
            begin
                w.lane[d]     = req_ch.feat_a[16*d +: 16];
                w.lane[4 + d] = req_ch.feat_b[16*d +: 16];
                w.lane[8 + d] = req_ch.feat_c[16*d +: 16];
            end
            w.lane[12] = req_ch.feat_d[15:0];
            w.lane[13] = req_ch.feat_d[31:16];
            if (w.req_type == REQ_LOAD)
            begin
                stored_lane[w.entry_index]  = w.lane;
                stored_fraud[w.entry_index] = w.is_fraud;
            end
            else
                expected_scores.push_back(score_query(w));
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        knn_score_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_scores.size() == 0)
            begin
                $error("result word with no query outstanding");
                failures++;
            end
            else
            begin
                e = expected_scores.pop_front();
                if (res_ch.fraud_hits !== e.fraud_hits)
                begin
                    $error("fraud_hits expected %0d actual %0d", e.fraud_hits,
                           res_ch.fraud_hits);
                    failures++;
                end
                if (res_ch.neighbor_count !== e.neighbor_count)
                begin
                    $error("neighbor_count expected %0d actual %0d", e.neighbor_count,
                           res_ch.neighbor_count);
                    failures++;
                end
                if (res_ch.score !== e.score)
                begin
                    $error("score expected %0d actual %0d", e.score, res_ch.score);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus
    initial
    begin
        knn_word_t w;
        int        slot;
        int        src;
        failures = 0;
        quiet = 1'b0;
        send_gap = 0;
        hold_left = 0;
        long_hold_requests = 0;
        long_hold_done = 0;
        idle_cycles = 0;
        req_took = 1'b0;
        search_count = 0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_LOAD;
        req_ch.entry_index = '0;
        req_ch.feat_a = '0;
        req_ch.feat_b = '0;
        req_ch.feat_c = '0;
        req_ch.feat_d = '0;
        req_ch.is_fraud = 1'b0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no entries: empty score, both at reset count and after writing zero
        pending_words.push_back(flat_word(REQ_QUERY, 0, 0, 16'h0000));
        write_count(0);
        pending_words.push_back(flat_word(REQ_QUERY, 0, 1, 16'h7FFF));

        // extremes and a run of equal distances
        push_load(flat_word(REQ_LOAD, 0, 1, 16'h7FFF));
        push_load(flat_word(REQ_LOAD, 1, 0, 16'h8000));
        for (int s = 2; s < 7; s++)
            push_load(flat_word(REQ_LOAD, s, s[0] ? 1'b0 : 1'b1, 16'h0000));
        push_load(flat_word(REQ_LOAD, 7, 0, 16'h0001));

        // fewer entries than neighbors, then all eight loaded entries
        write_count(3);
        pending_words.push_back(flat_word(REQ_QUERY, 0, 0, 16'h0000));
        pending_words.push_back(flat_word(REQ_QUERY, 0, 0, 16'h8000));
        write_count(8);
        pending_words.push_back(flat_word(REQ_QUERY, 0, 0, 16'h0000));
        pending_words.push_back(flat_word(REQ_QUERY, 0, 0, 16'h7FFF));
        pending_words.push_back(flat_word(REQ_QUERY, 0, 0, 16'h8000));
        w = flat_word(REQ_QUERY, 0, 0, 16'h0000);
        for (int d = 0; d < FEATS; d++)
            w.lane[d] = random_lane();
        pending_words.push_back(w);

        // fill the near slots so random queries read only written entries
        for (int s = 8; s < NEAR_SLOTS; s++)
        begin
            w = flat_word(REQ_LOAD, s, 1'($urandom_range(0, 1)), 16'h0000);
            for (int d = 0; d < FEATS; d++)
                w.lane[d] = random_lane();
            push_load(w);
        end

        // random phases over several counts, the last one with no idling
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_count(NEAREST);
                1: write_count(1);
                2: write_count(NEAR_SLOTS);
                default: write_count($urandom_range(2, NEAR_SLOTS));
            endcase
            if (phase == 2)
                long_hold_requests++;
            if (phase == 4)
                quiet = 1'b1;
            for (int i = 0; i < 20; i++)
            begin
                w = flat_word(REQ_QUERY, 0, 1'($urandom_range(0, 1)), 16'h0000);
                if ($urandom_range(0, 9) < 4)
                begin
                    slot = ($urandom_range(0, 7) == 0) ? $urandom_range(0, SLOTS - 1)
                                                       : $urandom_range(0, NEAR_SLOTS - 1);
                    w.entry_index = 12'(slot);
                    src = $urandom_range(0, NEAR_SLOTS - 1);
                    // some loads copy lanes of another vector so distances can tie
                    for (int d = 0; d < FEATS; d++)
                        w.lane[d] = ($urandom_range(0, 3) == 0) ? plan_lane[src][d]
                                                                : random_lane();
                    push_load(w);
                end
                else
                begin
                    w.entry_index = 12'($urandom);
                    src = $urandom_range(0, NEAR_SLOTS - 1);
                    for (int d = 0; d < FEATS; d++)
                        w.lane[d] = $urandom_range(0, 1)
                                    ? plan_lane[src][d] + 16'($urandom_range(0, 15)) - 16'd8
                                    : random_lane();
                    pending_words.push_back(w);
                end
            end
        end

        settle();
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
sv/knn_pkg.sv
sv/knn_ifc.sv
sv/knn_ram.sv
sv/knn_ctrl.sv
sv/knn_dp.sv
sv/knn_five_fraud_score_unit.sv
dv/tb.sv
